/* rtl/bbg_pkg.sv */
// ----------------------------------------------------------------------------
// bbg_pkg
// Shared constants and types for the 3x3 grayscale box blur core.
// ----------------------------------------------------------------------------
package bbg_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  // Field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LB_W    = 2 * PIX_W;

  // Arithmetic widths: three pixels, nine pixels, product
  localparam int unsigned TRI_W  = PIX_W + 2;
  localparam int unsigned SUM_W  = PIX_W + 4;
  localparam int unsigned MUL_W  = 13;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  localparam int unsigned SHIFT  = 16;

  // Rounded divide by nine: ((sum + 4) * 7282) >> 16
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(4);
  localparam logic [MUL_W-1:0] NINTH_MUL  = MUL_W'(7282);

  // Register indices
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the last column / last row (size minus one)
  localparam logic [COORD_W-1:0] LAST_COL_RST = COORD_W'(639);
  localparam logic [COORD_W-1:0] LAST_ROW_RST = COORD_W'(479);

  // Line buffer write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LB_W-1:0]   data;
  } lb_wr_t;

  // Clamp a written size to 3..max and return size minus one
  function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] c;
    begin
      if (v < DIM_W'(3)) begin
        c = DIM_W'(3);
      end else if (v > hi) begin
        c = hi;
      end else begin
        c = v;
      end
      dim_last = COORD_W'(c - DIM_W'(1));
    end
  endfunction

endpackage

/* rtl/bbg_line_buf.sv */
// ----------------------------------------------------------------------------
// bbg_line_buf
// Combined line buffer: one entry per column holding the pixels of the rows
// two up (upper byte) and one up (lower byte). Registered read, one write.
// ----------------------------------------------------------------------------
module bbg_line_buf
  import bbg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [LB_W-1:0]   rd_data_o,
  input  lb_wr_t            wr_i
);

  logic [LB_W-1:0] mem [MAX_WIDTH];
  logic [LB_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/box_blur_3x3_gray_core.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_gray_core
// 3x3 box blur over an 8-bit grayscale raster stream; one result per interior
// pixel, none for the frame border.
// ----------------------------------------------------------------------------
// Path: an item passes the stage 1 and stage 2 registers into the output register.
// Throughput: one pixel per cycle while the output is not stalled; the line buffer is
//   read as an item is taken and written back one stage later, at a different column.
// Reset: counters, window and pipeline valids clear; sizes return to 640x480.
//   Line buffer contents are undefined until the first two rows have passed.
// ----------------------------------------------------------------------------
module box_blur_3x3_gray_core
  import bbg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  // pixel input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIX_W-1:0]   pixel_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   blurred_value_o,
  output logic [COORD_W-1:0] out_column_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic               frame_end_o
);

  // Configuration, stored as size minus one
  logic [COORD_W-1:0] last_col_q, last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LAST_COL_RST;
      last_row_q <= LAST_ROW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  last_col_q <= dim_last(cfg_data_i, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: last_row_q <= dim_last(cfg_data_i, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the next has room
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_acc;

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && rdy1;

  // Position counters
  logic [COORD_W-1:0] col_q, row_q;
  logic               is_last_col, is_last_row;

  assign is_last_col = col_q >= last_col_q;
  assign is_last_row = row_q >= last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (is_last_col) begin
        col_q <= '0;
        row_q <= is_last_row ? '0 : row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COORD_W'(1);
      end
    end
  end

  // Line buffer: read at the incoming column, write back from stage 1.
  // Consecutive items always sit at different columns (width is at least 3),
  // and an entry is read again only a full row later, so no forwarding.
  logic [LB_W-1:0] lb_rd;
  lb_wr_t          lb_wr;

  bbg_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (ADDR_W'(col_q)),
    .rd_data_o (lb_rd),
    .wr_i      (lb_wr)
  );

  // Stage 1: pixel and position, line buffer data arrives
  logic [PIX_W-1:0]   px1_q;
  logic [COORD_W-1:0] col1_q, row1_q;
  logic               emit1_q, fend1_q;
  logic               adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q   <= pixel_i;
      col1_q  <= col_q;
      row1_q  <= row_q;
      emit1_q <= (row_q >= COORD_W'(2)) && (col_q >= COORD_W'(2));
      fend1_q <= is_last_col && is_last_row;
    end
  end

  assign adv1 = v1_q && rdy2;

  // Shift the column down the line buffer: one-up moves to two-up
  assign lb_wr.en   = adv1;
  assign lb_wr.addr = ADDR_W'(col1_q);
  assign lb_wr.data = {lb_rd[PIX_W-1:0], px1_q};

  // Window of the two previous column sums
  logic [TRI_W-1:0] win0_q, win1_q, cur_sum;
  logic [SUM_W-1:0] sum_d;

  assign cur_sum = TRI_W'(lb_rd[LB_W-1:PIX_W]) + TRI_W'(lb_rd[PIX_W-1:0])
                 + TRI_W'(px1_q);
  assign sum_d   = SUM_W'(win0_q) + SUM_W'(win1_q) + SUM_W'(cur_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (adv1) begin
      win0_q <= win1_q;
      win1_q <= cur_sum;
    end
  end

  // Stage 2: nine-pixel sum and centre position
  logic [SUM_W-1:0]   sum2_q;
  logic [COORD_W-1:0] col2_q, row2_q;
  logic               fend2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      sum2_q  <= sum_d;
      col2_q  <= col1_q - COORD_W'(1);
      row2_q  <= row1_q - COORD_W'(1);
      fend2_q <= fend1_q;
    end
  end

  // Stage 3: rounded divide by nine, clamp, output register
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-SHIFT-1:0] quot;
  logic [PIX_W-1:0]        mean;

  assign prod = PROD_W'(sum2_q + ROUND_BIAS) * PROD_W'(NINTH_MUL);
  assign quot = prod[PROD_W-1:SHIFT];
  assign mean = (quot > (PROD_W-SHIFT)'({PIX_W{1'b1}})) ? {PIX_W{1'b1}}
                                                          : PIX_W'(quot);

  logic [PIX_W-1:0]   val3_q;
  logic [COORD_W-1:0] col3_q, row3_q;
  logic               fend3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      val3_q  <= mean;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
      fend3_q <= fend2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign blurred_value_o = val3_q;
  assign out_column_o    = col3_q;
  assign out_row_o       = row3_q;
  assign frame_end_o     = fend3_q;

endmodule

/* rtl/bbg_checker.sv */
// ----------------------------------------------------------------------------
// bbg_checker
// Port-level checks for the box blur core, attached by bind.
// ----------------------------------------------------------------------------
module bbg_checker
  import bbg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PIX_W-1:0]   blurred_value_o,
  input logic [COORD_W-1:0] out_column_o,
  input logic [COORD_W-1:0] out_row_o,
  input logic               frame_end_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(blurred_value_o)
      && $stable(out_column_o) && $stable(out_row_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // A result is only withdrawn after it was taken
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // Pixels in the first column or first row give no result
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_column_o != '0 && out_row_o != '0)
    else $error("result for a border pixel");

  // Input backpressure only arises from a stalled, full output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

endmodule

bind box_blur_3x3_gray_core bbg_checker u_bbg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .blurred_value_o (blurred_value_o),
  .out_column_o    (out_column_o),
  .out_row_o       (out_row_o),
  .frame_end_o     (frame_end_o)
);
